FILE: rtl/mva_pkg.sv
package mva_pkg;

	typedef struct packed {
		logic [7:0]  status_byte;
		logic [7:0]  data_one;
		logic [7:0]  data_two;
		logic [12:0] avail_bytes;
	} msg_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [3:0]  voice;
		logic [7:0]  note_number;
		logic [7:0]  velocity;
		logic [1:0]  param_index;
		logic [28:0] value;
		logic [12:0] used_bytes;
		logic        last;
	} evt_t;

	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_START   = 3'd1;
	localparam logic [2:0] EV_RELEASE = 3'd2;
	localparam logic [2:0] EV_FILTER  = 3'd3;
	localparam logic [2:0] EV_BEND    = 3'd4;
	localparam logic [2:0] EV_PROGRAM = 3'd5;

	localparam logic [3:0] TY_NOTE_OFF = 4'h8;
	localparam logic [3:0] TY_NOTE_ON  = 4'h9;
	localparam logic [3:0] TY_CTRL     = 4'hB;
	localparam logic [3:0] TY_PROGRAM  = 4'hC;
	localparam logic [7:0] ST_BEND     = 8'hE0;

	localparam logic [7:0] CC_CUTOFF   = 8'd1;
	localparam logic [7:0] CC_RESO_A   = 8'd2;
	localparam logic [7:0] CC_RESO_B   = 8'd3;
	localparam logic [7:0] CC_SUSTAIN  = 8'd64;

	localparam logic [28:0] CUTOFF_BASE = 29'd142365917;
	localparam logic [19:0] CUTOFF_STEP = 20'd917175;
	localparam logic [19:0] RESO_STEP   = 20'd528416;
	localparam logic [7:0]  PROG_MAX    = 8'd31;
	localparam int          MAX_RESULTS = 16;

	// scan modes of the voice walk
	typedef enum logic [1:0] {
		SCAN_OFF,
		SCAN_ON,
		SCAN_PEDAL
	} scan_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_EMIT,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic  load;
		logic  start_scan;
		scan_t mode;
		logic  step;
		logic  emit_hit;
		logic  emit_single;
		logic  emit_final;
	} cmd_t;

	typedef struct packed {
		logic  scan_done;
		logic  hit;
		logic  single;
		scan_t mode;
		logic  scan_req;
		logic  any_emitted;
		logic  full;
	} sts_t;

endpackage

FILE: rtl/mva_datapath.sv
module mva_datapath #(
	parameter int VOICES = 16,
	parameter int VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mva_pkg::msg_t msg,
	input  mva_pkg::cmd_t cmd,
	output mva_pkg::sts_t sts,
	output mva_pkg::evt_t evt
);

	mva_pkg::msg_t m_q;
	logic [7:0]    note_q [VOICES];
	logic [VOICES-1:0] held_q, sus_q;
	logic [VW-1:0] next_q, idx_q;
	logic [VW:0]   cnt_q;
	logic          sustain_q;
	logic [4:0]    nemit_q;

	logic [3:0]  ty;
	logic        is_off, is_on, is_ctl, is_prg, is_bnd, avail3, avail2;
	logic        hit;
	logic [12:0] consumed;
	logic [VW-1:0] idx_inc;
	logic [VOICES-1:0] later_hits;
	logic        more;
	mva_pkg::evt_t evt_d;

	// filter word multiply, one product before the register
	logic [28:0] prod;

	always_comb begin
		ty      = m_q.status_byte[7:4];
		avail3  = m_q.avail_bytes >= 13'd3;
		avail2  = m_q.avail_bytes >= 13'd2;
		is_off  = (ty == mva_pkg::TY_NOTE_OFF) ||
			(ty == mva_pkg::TY_NOTE_ON && m_q.data_two == 8'd0);
		is_on   = ty == mva_pkg::TY_NOTE_ON && !is_off;
		is_ctl  = ty == mva_pkg::TY_CTRL;
		is_prg  = ty == mva_pkg::TY_PROGRAM;
		is_bnd  = m_q.status_byte == mva_pkg::ST_BEND;
		if (is_off || is_on || is_ctl)
			consumed = avail3 ? 13'd3 : 13'd0;
		else if (is_prg)
			consumed = avail2 ? 13'd2 : 13'd0;
		else if (is_bnd)
			consumed = 13'd3;
		else
			consumed = m_q.avail_bytes;
		if (idx_q == VW'(VOICES - 1))
			idx_inc = '0;
		else
			idx_inc = idx_q + VW'(1);
		case (cmd.mode)
			mva_pkg::SCAN_OFF:   hit = held_q[idx_q] && note_q[idx_q] == m_q.data_one;
			mva_pkg::SCAN_ON:    hit = !held_q[idx_q];
			mva_pkg::SCAN_PEDAL: hit = sus_q[idx_q] && !held_q[idx_q];
			default:             hit = 1'b0;
		endcase
		if (m_q.data_one == mva_pkg::CC_CUTOFF)
			prod = mva_pkg::CUTOFF_BASE + 29'(m_q.data_two) * 29'(mva_pkg::CUTOFF_STEP);
		else
			prod = 29'(m_q.data_two) * 29'(mva_pkg::RESO_STEP);
	end

	// release walks go upward from voice 0; a hit is the final item when no later voice hits or the event cap is reached
	always_comb begin
		for (int i = 0; i < VOICES; i++) begin
			if (cmd.mode == mva_pkg::SCAN_PEDAL)
				later_hits[i] = sus_q[i] && !held_q[i] && i > int'(idx_q);
			else
				later_hits[i] = held_q[i] && note_q[i] == m_q.data_one && i > int'(idx_q);
		end
		more = |later_hits;
	end

	always_comb begin
		// a note-off under the pedal only moves the voice to sustained
		sts.hit         = hit && !(cmd.mode == mva_pkg::SCAN_OFF && sustain_q);
		sts.scan_done   = cnt_q == (VW+1)'(VOICES - 1);
		sts.any_emitted = nemit_q != 5'd0;
		sts.full        = nemit_q == 5'(mva_pkg::MAX_RESULTS);
		sts.scan_req    = 1'b0;
		sts.single      = 1'b0;
		sts.mode        = mva_pkg::SCAN_OFF;
		if ((is_off || is_on) && avail3) begin
			sts.scan_req = 1'b1;
			sts.mode     = is_on ? mva_pkg::SCAN_ON : mva_pkg::SCAN_OFF;
		end else if (is_ctl && avail3) begin
			if (m_q.data_one == mva_pkg::CC_CUTOFF || m_q.data_one == mva_pkg::CC_RESO_A ||
				m_q.data_one == mva_pkg::CC_RESO_B)
				sts.single = 1'b1;
			else if (m_q.data_one == mva_pkg::CC_SUSTAIN && m_q.data_two == 8'd0) begin
				sts.scan_req = 1'b1;
				sts.mode     = mva_pkg::SCAN_PEDAL;
			end
		end else if ((is_prg && avail2) || is_bnd)
			sts.single = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			m_q <= msg;
		if (cmd.step && hit && cmd.mode == mva_pkg::SCAN_ON)
			note_q[idx_q] <= m_q.data_one;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			sus_q     <= '0;
			next_q    <= '0;
			idx_q     <= '0;
			cnt_q     <= '0;
			sustain_q <= 1'b0;
			nemit_q   <= '0;
		end else begin
			if (cmd.load)
				nemit_q <= '0;
			if (cmd.start_scan) begin
				idx_q <= (cmd.mode == mva_pkg::SCAN_ON) ? next_q : '0;
				cnt_q <= '0;
				if (is_ctl && avail3 && m_q.data_one == mva_pkg::CC_SUSTAIN)
					sustain_q <= m_q.data_two != 8'd0;
			end
			if (cmd.step) begin
				idx_q <= idx_inc;
				cnt_q <= cnt_q + (VW+1)'(1);
				if (hit) begin
					case (cmd.mode)
						mva_pkg::SCAN_OFF: begin
							held_q[idx_q] <= 1'b0;
							if (sustain_q)
								sus_q[idx_q] <= 1'b1;
						end
						mva_pkg::SCAN_ON: begin
							held_q[idx_q] <= 1'b1;
							sus_q[idx_q]  <= sustain_q;
							next_q        <= idx_inc;
						end
						mva_pkg::SCAN_PEDAL: sus_q[idx_q] <= 1'b0;
						default: ;
					endcase
				end
			end
			if (cmd.emit_hit || cmd.emit_single)
				nemit_q <= nemit_q + 5'd1;
		end
	end

	always_comb begin
		evt_d = '0;
		evt_d.used_bytes = consumed;
		evt_d.last = !cmd.emit_hit || cmd.mode == mva_pkg::SCAN_ON || !more ||
			nemit_q == 5'(mva_pkg::MAX_RESULTS - 1);
		if (cmd.emit_hit) begin
			evt_d.voice       = 4'(idx_q);
			evt_d.event_kind  = (cmd.mode == mva_pkg::SCAN_ON) ?
				mva_pkg::EV_START : mva_pkg::EV_RELEASE;
			evt_d.note_number = (cmd.mode == mva_pkg::SCAN_ON) ? m_q.data_one : note_q[idx_q];
			evt_d.velocity    = (cmd.mode == mva_pkg::SCAN_ON) ? m_q.data_two : 8'd0;
		end else if (cmd.emit_single) begin
			if (is_ctl) begin
				evt_d.event_kind  = mva_pkg::EV_FILTER;
				evt_d.param_index = 2'(m_q.data_one - 8'd1);
				evt_d.value       = prod;
			end else if (is_prg) begin
				evt_d.event_kind = mva_pkg::EV_PROGRAM;
				evt_d.value = 29'((m_q.data_one < mva_pkg::PROG_MAX) ?
					m_q.data_one : mva_pkg::PROG_MAX);
			end else begin
				evt_d.event_kind = mva_pkg::EV_BEND;
				evt_d.value      = 29'({m_q.data_two, 7'd0}) | 29'(m_q.data_one);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_hit || cmd.emit_single || cmd.emit_final)
			evt <= evt_d;
	end

`ifndef SYNTH
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> cnt_q < (VW+1)'(VOICES)) else $error("scan ran past last voice");
	a_emit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_hit |-> nemit_q < 5'(mva_pkg::MAX_RESULTS)) else $error("too many events");
	a_on_one: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && hit && cmd.mode == mva_pkg::SCAN_ON) |=> held_q[$past(idx_q)])
		else $error("started voice not held");
`endif

endmodule

FILE: rtl/mva_ctrl.sv
module mva_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  mva_pkg::sts_t sts,
	output mva_pkg::cmd_t cmd
);

	mva_pkg::state_t state_q, state_d;
	mva_pkg::scan_t  mode_q, mode_d;
	logic            ov_q, ov_d;
	logic            free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mva_pkg::ST_IDLE;
			mode_q  <= mva_pkg::SCAN_OFF;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			ov_q    <= ov_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mode_d   = mode_q;
		cmd      = '0;
		cmd.mode = mode_q;
		free     = !ov_q || !out_stall;
		ov_d     = ov_q && out_stall;
		in_stall = 1'b1;
		case (state_q)
			mva_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = mva_pkg::ST_DECODE;
				end
			end
			mva_pkg::ST_DECODE: begin
				cmd.start_scan = 1'b1;
				cmd.mode       = sts.mode;
				mode_d         = sts.mode;
				if (sts.scan_req)
					state_d = mva_pkg::ST_SCAN;
				else if (sts.single)
					state_d = mva_pkg::ST_EMIT;
				else
					state_d = mva_pkg::ST_FINAL;
			end
			mva_pkg::ST_SCAN: begin
				// a hit waits for the output register before the voice moves on
				if (!(sts.hit && !sts.full && !free)) begin
					cmd.step = 1'b1;
					if (sts.hit && !sts.full) begin
						cmd.emit_hit = 1'b1;
						ov_d = 1'b1;
					end
					if (sts.scan_done || (sts.hit && mode_q == mva_pkg::SCAN_ON))
						state_d = mva_pkg::ST_FINAL;
				end
			end
			mva_pkg::ST_EMIT: if (free) begin
				cmd.emit_single = 1'b1;
				ov_d    = 1'b1;
				state_d = mva_pkg::ST_IDLE;
			end
			mva_pkg::ST_FINAL: if (free) begin
				// last flag rides on an extra kind-0 item only if nothing was sent
				if (sts.any_emitted)
					state_d = mva_pkg::ST_IDLE;
				else begin
					cmd.emit_final = 1'b1;
					ov_d    = 1'b1;
					state_d = mva_pkg::ST_IDLE;
				end
			end
			default: state_d = mva_pkg::ST_IDLE;
		endcase
		out_valid = ov_q;
	end

`ifndef SYNTH
	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> state_q == mva_pkg::ST_IDLE) else $error("accept outside idle");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_hit || cmd.emit_single || cmd.emit_final) |-> free)
		else $error("overwrote pending item");
	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_hit, cmd.emit_single, cmd.emit_final})) else $error("emit clash");
`endif

endmodule

FILE: rtl/midi_voice_allocator_core.sv
// MIDI round-robin voice allocator.
// Input channel msg (valid/stall): one MIDI message with its byte count.
// Output channel evt (valid/stall): one or more events per message, the
// final one flagged by last; every event carries used_bytes.
// A message is taken only while the block is idle: it is registered,
// then decoded, then either one event is formed, a walk over the voices
// at one voice per cycle runs for note-on, note-off and sustain release,
// or only a kind-0 item flagged last goes out. Events are formed
// combinationally and held in the output register; when the receiver
// stalls the walk waits on the next voice that would emit. The walk and
// event count set the rate; at most 16 events go out per message,
// further releases change state silently.
// Reset clears all voice marks, the round-robin pointer and the pedal.
module midi_voice_allocator_core #(
	parameter int VOICES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          msg_valid,
	output logic          msg_stall,
	input  mva_pkg::msg_t msg,
	output logic          evt_valid,
	input  logic          evt_stall,
	output mva_pkg::evt_t evt
);

	mva_pkg::cmd_t cmd;
	mva_pkg::sts_t sts;

	mva_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (msg_valid),
		.in_stall  (msg_stall),
		.out_valid (evt_valid),
		.out_stall (evt_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mva_datapath #(.VOICES(VOICES)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.cmd    (cmd),
		.sts    (sts),
		.evt    (evt)
	);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int NVOICE = 16;
	localparam int CYCLE_LIMIT = 400000;

	logic  clk;
	logic  arst_n;
	logic  msg_valid;
	logic  msg_stall;
	mva_pkg::msg_t msg;
	logic  evt_valid;
	logic  evt_stall;
	mva_pkg::evt_t evt;

	midi_voice_allocator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.msg_valid(msg_valid),
		.msg_stall(msg_stall),
		.msg(msg),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt)
	);

	// predicted allocator state
	logic [7:0] note_of [NVOICE];
	logic       held [NVOICE];
	logic       sustained [NVOICE];
	int         rr_ptr;
	logic       pedal_down;

	mva_pkg::evt_t events_due[$];
	int   mismatches;
	int   cycles;
	int   send_idle_pct;
	int   recv_idle_pct;
	bit   hold_off;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[midi_voice_allocator_core] ERROR");
			$finish;
		end
	end

	// receiver stall
	always @(posedge clk) begin
		if (!arst_n)
			evt_stall <= 1'b0;
		else
			evt_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
	end

	// result checker
	always @(posedge clk) begin
		mva_pkg::evt_t want;
		if (arst_n && evt_valid && !evt_stall) begin
			if (events_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected event %h", evt);
			end else begin
				want = events_due.pop_front();
				if (evt !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("event mismatch: expected %h actual %h", want, evt);
				end
			end
		end
	end

	function automatic mva_pkg::evt_t blank_event();
		mva_pkg::evt_t e;
		e = '0;
		return e;
	endfunction

	task automatic add_event(inout int n, input mva_pkg::evt_t e);
		if (n < mva_pkg::MAX_RESULTS)
			events_due.push_back(e);
		n++;
	endtask

	// compute the events caused by one message and update the state
	task automatic allocate_events(input mva_pkg::msg_t m);
		logic [3:0] ty;
		int         n;
		int         v;
		int         first;
		logic [12:0] used;
		mva_pkg::evt_t e;
		ty = m.status_byte[7:4];
		n = 0;
		first = events_due.size();
		used = 0;
		e = blank_event();
		if (ty == mva_pkg::TY_NOTE_OFF || (ty == mva_pkg::TY_NOTE_ON && m.data_two == 0)) begin
			if (m.avail_bytes >= 3) begin
				for (int i = 0; i < NVOICE; i++)
					if (held[i] && note_of[i] == m.data_one) begin
						if (pedal_down)
							sustained[i] = 1'b1;
						else begin
							e = blank_event();
							e.event_kind = mva_pkg::EV_RELEASE;
							e.voice = i[3:0];
							e.note_number = note_of[i];
							add_event(n, e);
						end
						held[i] = 1'b0;
					end
				used = 3;
			end
		end else if (ty == mva_pkg::TY_NOTE_ON) begin
			if (m.avail_bytes >= 3) begin
				v = rr_ptr;
				for (int i = 0; i < NVOICE; i++) begin
					if (!held[v]) begin
						rr_ptr = (v + 1) % NVOICE;
						note_of[v] = m.data_one;
						held[v] = 1'b1;
						sustained[v] = pedal_down;
						e = blank_event();
						e.event_kind = mva_pkg::EV_START;
						e.voice = v[3:0];
						e.note_number = m.data_one;
						e.velocity = m.data_two;
						add_event(n, e);
						break;
					end
					v = (v + 1) % NVOICE;
				end
				used = 3;
			end
		end else if (ty == mva_pkg::TY_CTRL) begin
			if (m.avail_bytes >= 3) begin
				e.event_kind = mva_pkg::EV_FILTER;
				if (m.data_one == mva_pkg::CC_CUTOFF) begin
					e.value = 29'(142365917 + m.data_two * 917175);
					add_event(n, e);
				end else if (m.data_one == mva_pkg::CC_RESO_A ||
					m.data_one == mva_pkg::CC_RESO_B) begin
					e.param_index = (m.data_one == mva_pkg::CC_RESO_A) ? 2'd1 : 2'd2;
					e.value = 29'(m.data_two * 528416);
					add_event(n, e);
				end else if (m.data_one == mva_pkg::CC_SUSTAIN) begin
					pedal_down = (m.data_two != 0);
					if (!pedal_down)
						for (int i = 0; i < NVOICE; i++)
							if (sustained[i] && !held[i]) begin
								e = blank_event();
								e.event_kind = mva_pkg::EV_RELEASE;
								e.voice = i[3:0];
								e.note_number = note_of[i];
								add_event(n, e);
								sustained[i] = 1'b0;
							end
				end
				used = 3;
			end
		end else if (ty == mva_pkg::TY_PROGRAM) begin
			if (m.avail_bytes >= 2) begin
				e.event_kind = mva_pkg::EV_PROGRAM;
				e.value = (m.data_one < mva_pkg::PROG_MAX) ? 29'(m.data_one) :
					29'(mva_pkg::PROG_MAX);
				add_event(n, e);
				used = 2;
			end
		end else if (m.status_byte == mva_pkg::ST_BEND) begin
			e.event_kind = mva_pkg::EV_BEND;
			e.value = 29'({m.data_two, 7'b0} | m.data_one);
			add_event(n, e);
			used = 3;
		end else
			used = m.avail_bytes;
		if (n == 0)
			add_event(n, blank_event());
		for (int k = first; k < events_due.size(); k++)
			events_due[k].used_bytes = used;
		events_due[events_due.size() - 1].last = 1'b1;
	endtask

	task automatic send_msg(input logic [7:0] st, input logic [7:0] d1, input logic [7:0] d2,
			input logic [12:0] avail);
		mva_pkg::msg_t m;
		m = '{status_byte: st, data_one: d1, data_two: d2, avail_bytes: avail};
		while ($urandom_range(99) < send_idle_pct) begin
			msg_valid <= 1'b0;
			@(posedge clk);
		end
		msg_valid <= 1'b1;
		msg <= m;
		allocate_events(m);
		@(posedge clk);
		while (msg_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		msg_valid <= 1'b0;
		while (events_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic rand_msg();
		int pick;
		logic [7:0] hi;
		pick = $urandom_range(99);
		if (pick < 35)
			hi = 8'h90;
		else if (pick < 60)
			hi = 8'h80;
		else if (pick < 75)
			hi = 8'hB0;
		else
			hi = 8'($urandom_range(255));
		if (pick < 60)
			send_msg(hi | 8'($urandom_range(15)), 8'($urandom_range(36, 43)),
				(pick < 35 && $urandom_range(9) == 0) ? 8'd0 : 8'($urandom),
				($urandom_range(19) == 0) ? 13'($urandom_range(2)) : 13'($urandom));
		else if (pick < 75)
			send_msg(hi, ($urandom_range(1) == 0) ? mva_pkg::CC_SUSTAIN :
				8'($urandom_range(5)),
				($urandom_range(2) == 0) ? 8'd0 : 8'($urandom), 13'($urandom));
		else
			send_msg(hi, 8'($urandom), 8'($urandom), 13'($urandom));
	endtask

	task automatic test_directed();
		send_msg(8'h90, 8'd60, 8'd100, 13'd3);
		send_msg(8'h90, 8'd60, 8'd255, 13'd8191);
		send_msg(8'h91, 8'd61, 8'd1, 13'd2);
		send_msg(8'h80, 8'd60, 8'd0, 13'd3);
		send_msg(8'hB0, mva_pkg::CC_SUSTAIN, 8'd127, 13'd3);
		send_msg(8'h90, 8'd70, 8'd50, 13'd3);
		send_msg(8'h90, 8'd70, 8'd0, 13'd3);
		send_msg(8'hB0, mva_pkg::CC_SUSTAIN, 8'd0, 13'd3);
		send_msg(8'h80, 8'd70, 8'd0, 13'd3);
		send_msg(8'hB0, mva_pkg::CC_CUTOFF, 8'd255, 13'd3);
		send_msg(8'hB0, mva_pkg::CC_RESO_A, 8'd0, 13'd3);
		send_msg(8'hBF, mva_pkg::CC_RESO_B, 8'd255, 13'd3);
		send_msg(8'hB0, 8'd7, 8'd9, 13'd3);
		send_msg(8'hC0, 8'd255, 8'd0, 13'd2);
		send_msg(8'hC3, 8'd5, 8'd0, 13'd1);
		send_msg(8'hE0, 8'd255, 8'd255, 13'd0);
		send_msg(8'hE1, 8'd1, 8'd2, 13'd8191);
		send_msg(8'hF0, 8'd0, 8'd0, 13'd77);
		send_msg(8'hA0, 8'd0, 8'd0, 13'd0);
		drain();
	endtask

	// fill every voice under the pedal, then one more, then release all at once
	task automatic test_voice_overflow();
		send_msg(8'hB0, mva_pkg::CC_SUSTAIN, 8'd1, 13'd3);
		for (int i = 0; i < 17; i++)
			send_msg(8'h90, 8'd50, 8'(i + 1), 13'd3);
		send_msg(8'h80, 8'd50, 8'd0, 13'd3);
		send_msg(8'hB0, mva_pkg::CC_SUSTAIN, 8'd0, 13'd3);
		drain();
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 12; i++)
				rand_msg();
		join
		drain();
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++)
			rand_msg();
		drain();
	endtask

	initial begin
		for (int i = 0; i < NVOICE; i++) begin
			note_of[i] = 0;
			held[i] = 0;
			sustained[i] = 0;
		end
		rr_ptr = 0;
		pedal_down = 0;
		mismatches = 0;
		cycles = 0;
		hold_off = 1'b0;
		send_idle_pct = 34;
		recv_idle_pct = 61;
		arst_n = 1'b0;
		msg_valid = 1'b0;
		msg = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_voice_overflow();
		test_backpressure();
		test_random(45);
		send_idle_pct = 61;
		recv_idle_pct = 34;
		test_random(45);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(45);
		if (mismatches == 0 && events_due.size() == 0)
			$display("[midi_voice_allocator_core] OK");
		else
			$display("[midi_voice_allocator_core] ERROR");
		$finish;
	end

endmodule
